// ===== design/smta_pkg.sv =====
// Shared types and constants for the sliding median threshold alert block.
// No dependencies; used by smta_cfg, smta_sort, smta_chk and the top level.
package smta_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

    // Register indexes (byte address = 4 * index)
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;

    // Window length register
    localparam int                WLEN_W     = 9;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd8;

    // Alert counter and result item packing
    localparam int                 COUNT_W   = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int                 M_DATA_W  = ((COUNT_W + 2 + 7) / 8) * 8;

    // Request from the top level to the sorted-store engine
    typedef struct packed {
        logic start;   // begin one merge sweep
        logic remove;  // window full: drop one copy of the oldest sample
    } t_sort_ctl;

endpackage

// ===== design/smta_cfg.sv =====
// Configuration register file: APB-style write/read of the window length,
// clear pulse on write, and the clamped effective length. Uses smta_pkg.
module smta_cfg #(
    parameter  int WINDOW_MAX = 256,
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [smta_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [smta_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [smta_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [LEN_W-1:0]                  o_eff_len,
    output logic                              o_clear
);

    localparam int CMP_W = (LEN_W > smta_pkg::WLEN_W) ? LEN_W : smta_pkg::WLEN_W;

    logic [smta_pkg::WLEN_W-1:0]    r_wlen;
    logic [smta_pkg::CFG_IDX_W-1:0] reg_idx;
    logic                           wl_sel;
    logic [CMP_W-1:0]               wl_ext;

    assign pready  = 1'b1;
    assign reg_idx = paddr[smta_pkg::CFG_ADDR_W-1:2];
    assign wl_sel  = (reg_idx == smta_pkg::REG_WINDOW_LENGTH);
    assign o_clear = psel && penable && pwrite && pready && wl_sel;

    // Window length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= smta_pkg::WLEN_RESET;
        end else if (o_clear) begin
            r_wlen <= pwdata[smta_pkg::WLEN_W-1:0];
        end
    end

    // Read back
    assign prdata = wl_sel ? smta_pkg::CFG_DATA_W'(r_wlen) : '0;

    // Zero counts as one; anything above the store depth saturates
    assign wl_ext = CMP_W'(r_wlen);
    always_comb begin
        if (r_wlen == '0) begin
            o_eff_len = LEN_W'(1);
        end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
            o_eff_len = LEN_W'(WINDOW_MAX);
        end else begin
            o_eff_len = LEN_W'(r_wlen);
        end
    end

endmodule

// ===== design/smta_sort.sv =====
// Sorted window store and its merge engine: one pass over the memory that
// drops one copy of the old sample when the window is full and inserts the new one. Uses smta_pkg.
module smta_sort #(
    parameter  int WINDOW_MAX  = 256,
    parameter  int SAMPLE_BITS = 16,
    localparam int LEN_W       = $clog2(WINDOW_MAX + 1),
    localparam int ADDR_W      = $clog2(WINDOW_MAX)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  smta_pkg::t_sort_ctl     i_ctl,
    input  logic [LEN_W-1:0]        i_count,
    input  logic [SAMPLE_BITS-1:0]  i_old,
    input  logic [SAMPLE_BITS-1:0]  i_new,
    input  logic [ADDR_W-1:0]       i_mid_lo_idx,
    input  logic [ADDR_W-1:0]       i_mid_hi_idx,
    output logic                    o_done,
    output logic [SAMPLE_BITS-1:0]  o_mid_lo,
    output logic [SAMPLE_BITS-1:0]  o_mid_hi
);

    logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];

    logic                   r_active, n_active;
    logic [LEN_W-1:0]       r_rd_idx;
    logic                   r_rd_vld;
    logic [ADDR_W-1:0]      r_proc_idx;
    logic [LEN_W-1:0]       r_wr_idx;
    logic [LEN_W-1:0]       r_count;
    logic [SAMPLE_BITS-1:0] r_old, r_new;
    logic [SAMPLE_BITS-1:0] r_carry, n_carry;
    logic                   r_carry_vld, n_carry_vld;
    logic                   r_inserted, n_inserted;
    logic                   r_removed, n_removed;
    logic [SAMPLE_BITS-1:0] r_rd_q;
    logic [SAMPLE_BITS-1:0] r_mid_lo, r_mid_hi;

    logic                   rd_en, proc, last;
    logic                   we;
    logic [SAMPLE_BITS-1:0] wd;

    assign rd_en = r_active && (r_rd_idx < r_count);
    assign proc  = r_active && r_rd_vld;
    assign last  = r_active && !rd_en && !r_rd_vld;

    // Memory: registered read, read returns the old entry on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_q <= mem[r_rd_idx[ADDR_W-1:0]];
        end
        if (we) begin
            mem[r_wr_idx[ADDR_W-1:0]] <= wd;
        end
    end

    // Merge step: one entry in, one entry out, a one-entry carry absorbs
    // the shift after the insertion point
    always_comb begin
        n_active    = r_active;
        n_carry     = r_carry;
        n_carry_vld = r_carry_vld;
        n_inserted  = r_inserted;
        n_removed   = r_removed;
        we          = 1'b0;
        wd          = r_rd_q;
        if (proc) begin
            if (!r_removed && (r_rd_q == r_old)) begin
                // first copy of the leaving sample: skip it
                n_removed = 1'b1;
                if (r_carry_vld) begin
                    we          = 1'b1;
                    wd          = r_carry;
                    n_carry_vld = 1'b0;
                end
            end else if (r_carry_vld) begin
                we      = 1'b1;
                wd      = r_carry;
                n_carry = r_rd_q;
            end else if (!r_inserted && (r_rd_q > r_new)) begin
                we          = 1'b1;
                wd          = r_new;
                n_inserted  = 1'b1;
                n_carry     = r_rd_q;
                n_carry_vld = 1'b1;
            end else begin
                we = 1'b1;
            end
        end
        if (last) begin
            // flush: pending carry or a new sample larger than all entries
            if (r_carry_vld) begin
                we          = 1'b1;
                wd          = r_carry;
                n_carry_vld = 1'b0;
            end else if (!r_inserted) begin
                we         = 1'b1;
                wd         = r_new;
                n_inserted = 1'b1;
            end
            n_active = 1'b0;
        end
    end

    // Sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_rd_vld <= 1'b0;
        end else if (i_ctl.start) begin
            r_active <= 1'b1;
            r_rd_vld <= 1'b0;
        end else begin
            r_active <= n_active;
            r_rd_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_count     <= i_count;
            r_old       <= i_old;
            r_new       <= i_new;
            r_carry_vld <= 1'b0;
            r_inserted  <= 1'b0;
            r_removed   <= !i_ctl.remove;
        end else begin
            if (rd_en) begin
                r_rd_idx   <= r_rd_idx + LEN_W'(1);
                r_proc_idx <= r_rd_idx[ADDR_W-1:0];
            end
            if (we) begin
                r_wr_idx <= r_wr_idx + LEN_W'(1);
            end
            r_carry     <= n_carry;
            r_carry_vld <= n_carry_vld;
            r_inserted  <= n_inserted;
            r_removed   <= n_removed;
        end
    end

    // Capture the middle entries of the window as they stream past
    always_ff @(posedge i_clk) begin
        if (proc && (r_proc_idx == i_mid_lo_idx)) begin
            r_mid_lo <= r_rd_q;
        end
        if (proc && (r_proc_idx == i_mid_hi_idx)) begin
            r_mid_hi <= r_rd_q;
        end
    end

    assign o_done   = last;
    assign o_mid_lo = r_mid_lo;
    assign o_mid_hi = r_mid_hi;

endmodule

// ===== design/sliding_median_threshold_alert_core.sv =====
// Top level of the sliding median threshold alert block: arrival ring memory,
// per-item sequencer and result register. Uses smta_pkg, smta_cfg, smta_sort.
//
// Usage:
//   Samples enter on the s_axis channel (tdata holds the sample), one result
//   item per sample leaves on the m_axis channel (alert, window_full and the
//   saturating alert count). The window length is set over the APB-style port
//   at byte address 0; a write there clears the window and the alert count.
//   Each sample takes one arrival-ring read, one merge sweep over the sorted
//   store and a pass through the result hold state. The sweep reads every
//   entry now in the window through the sorted memory's read port, so the
//   time per sample grows with the number of entries stored (the window
//   length once full). The result is presented when the output register is
//   free, and tready returns in that same cycle.
//   One item is worked on at a time; s_axis_tready is high only when idle.
//   The output register lets the next sample enter while a result waits.
//   If the receiver stalls, the next finished result holds in the engine
//   until the output register drains, and no further sample is accepted.
//   Reset: window length 8, empty window, alert count zero, no result valid.
//   The memories need no clearing pass; only filled entries are ever used.
module sliding_median_threshold_alert_core #(
    parameter  int WINDOW_MAX  = 256,
    parameter  int SAMPLE_BITS = 16,
    localparam int S_DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample item: [SAMPLE_BITS-1:0] sample
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [S_DATA_W-1:0]                 s_axis_tdata,
    // result item: [0] alert, [1] window_full, [33:2] alert_count
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [smta_pkg::M_DATA_W-1:0]       m_axis_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [smta_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [smta_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [smta_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int ADDR_W = $clog2(WINDOW_MAX);
    localparam int THR_W  = SAMPLE_BITS + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RING  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_SORT  = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;

    logic [2:0]                      r_state;
    logic [LEN_W-1:0]                r_fill;
    logic [ADDR_W-1:0]               r_ptr;
    logic [smta_pkg::COUNT_W-1:0]    r_count;
    logic [SAMPLE_BITS-1:0]          r_sample;
    logic                            r_full;
    logic                            r_alert;
    logic [SAMPLE_BITS-1:0]          r_ring_q;
    logic                            r_out_valid;
    logic                            r_out_alert;
    logic                            r_out_full;
    logic [smta_pkg::COUNT_W-1:0]    r_out_count;

    logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX];

    logic [LEN_W-1:0]        eff_len;
    logic                    cfg_clear;
    smta_pkg::t_sort_ctl     sort_ctl;
    logic                    sort_done;
    logic [SAMPLE_BITS-1:0]  mid_lo, mid_hi;
    logic [ADDR_W-1:0]       mid_hi_idx, mid_lo_idx;
    logic [THR_W-1:0]        thr;
    logic                    hit;
    logic                    in_acc;
    logic                    out_load;
    logic                    ring_we;
    logic [ADDR_W-1:0]       ring_wa;

    smta_cfg #(.WINDOW_MAX(WINDOW_MAX)) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_eff_len (eff_len),
        .o_clear   (cfg_clear)
    );

    // Middle positions of the sorted window
    assign mid_hi_idx = ADDR_W'(eff_len >> 1);
    assign mid_lo_idx = mid_hi_idx - ADDR_W'(1);

    assign sort_ctl.start  = (r_state == ST_START);
    assign sort_ctl.remove = r_full;

    smta_sort #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_sort (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (sort_ctl),
        .i_count      (r_full ? eff_len : r_fill),
        .i_old        (r_ring_q),
        .i_new        (r_sample),
        .i_mid_lo_idx (mid_lo_idx),
        .i_mid_hi_idx (mid_hi_idx),
        .o_done       (sort_done),
        .o_mid_lo     (mid_lo),
        .o_mid_hi     (mid_hi)
    );

    // Twice the median, exact: sum of the two middles or double the middle
    assign thr = eff_len[0] ? {mid_hi, 1'b0}
                            : (THR_W'(mid_lo) + THR_W'(mid_hi));
    assign hit = r_full && (THR_W'(r_sample) >= thr);

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == ST_HOLD) && (!r_out_valid || m_axis_tready);
    assign ring_we  = (r_state == ST_SORT) && sort_done;
    assign ring_wa  = r_full ? r_ptr : r_fill[ADDR_W-1:0];

    // Arrival ring: read the oldest sample, write the new one after the sweep
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RING) begin
            r_ring_q <= ring[r_ptr];
        end
        if (ring_we) begin
            ring[ring_wa] <= r_sample;
        end
    end

    // Sequencer and window bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_ptr   <= '0;
            r_count <= '0;
        end else if (cfg_clear) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_ptr   <= '0;
            r_count <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_RING;
                    end
                end
                ST_RING: begin
                    r_state <= ST_START;
                end
                ST_START: begin
                    r_state <= ST_SORT;
                end
                ST_SORT: begin
                    if (sort_done) begin
                        r_state <= ST_HOLD;
                        if (hit && (r_count != smta_pkg::COUNT_MAX)) begin
                            r_count <= r_count + smta_pkg::COUNT_W'(1);
                        end
                        if (r_full) begin
                            if ((LEN_W'(r_ptr) + LEN_W'(1)) == eff_len) begin
                                r_ptr <= '0;
                            end else begin
                                r_ptr <= r_ptr + ADDR_W'(1);
                            end
                        end else begin
                            r_fill <= r_fill + LEN_W'(1);
                            r_ptr  <= '0;
                        end
                    end
                end
                ST_HOLD: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Item payload captured at accept, alert flag at the end of the sweep
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_full   <= (r_fill == eff_len);
        end
        if (ring_we) begin
            r_alert <= hit;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_alert <= r_alert;
            r_out_full  <= r_full;
            r_out_count <= r_count;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = smta_pkg::M_DATA_W'({r_out_count, r_out_full, r_out_alert});

endmodule

// ===== design/smta_chk.sv =====
// Port-level checker for the sliding median threshold alert block, bound to
// the top level. Uses smta_pkg for port widths.
module smta_chk #(
    parameter int S_DATA_W = 16
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [S_DATA_W-1:0]              s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [smta_pkg::M_DATA_W-1:0]    m_axis_tdata,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite
);

    // No result item is left valid by reset
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // One sample at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !(psel && penable && pwrite)
        |=> !s_axis_tready)
        else $error("sample accepted while previous one in progress");

    // An alert is only raised over a full window
    a_alert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && !m_axis_tdata[1]))
        else $error("alert without full window");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind sliding_median_threshold_alert_core smta_chk #(.S_DATA_W(S_DATA_W)) u_smta_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite)
);
